// File: hdl/hex_record_page_programmer_unit_defines.svh
// ----------------------------------------------------------------------------
// Hex record page programmer - assertion macros
// Shared concurrent assertion forms; expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef HEX_RECORD_PAGE_PROGRAMMER_UNIT_DEFINES_SVH
`define HEX_RECORD_PAGE_PROGRAMMER_UNIT_DEFINES_SVH

// same-cycle implication
`define HRPP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hrpp: same-cycle check failed");

// next-cycle implication
`define HRPP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hrpp: next-cycle check failed");

`endif

// File: hdl/hrpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrpp_pkg
// Types and constants shared by the hex record page programmer.
// ----------------------------------------------------------------------------
package hrpp_pkg;

	// page size in bytes; must be a power of two
	localparam int PAGE_BYTES      = 256;
	localparam int MAX_RECORD_DATA = 32;

	localparam logic [19:0] PAGE_MASK    = 20'(PAGE_BYTES - 1);
	localparam logic [7:0]  MAX_DATA_LEN = 8'(MAX_RECORD_DATA);

	localparam int MAX_CMDS = 3;
	localparam int CNT_W    = $clog2(MAX_CMDS + 1);

	localparam logic [7:0] REC_DATA    = 8'd0;
	localparam logic [7:0] REC_EOF     = 8'd1;
	localparam logic [7:0] REC_EXT_SEG = 8'd2;

	typedef enum logic [2:0] {
		POS_SYNC,
		POS_LEN,
		POS_ALO,
		POS_AHI,
		POS_TYPE,
		POS_DATA,
		POS_CKSUM
	} field_pos_t;

	typedef enum logic [1:0] {
		OP_FILL  = 2'd0,
		OP_ERASE = 2'd1,
		OP_WRITE = 2'd2,
		OP_START = 2'd3
	} op_t;

	typedef struct packed {
		op_t         opcode;
		logic [19:0] address;
		logic [15:0] word;
	} cmd_t;

	typedef struct packed {
		cmd_t [MAX_CMDS-1:0] cmds;
		logic [CNT_W-1:0]    count;
	} cmd_bundle_t;

endpackage

// File: hdl/hex_record_page_programmer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_page_programmer_unit
// Turns a binary hex-record byte stream into page fill/erase/write commands.
// ----------------------------------------------------------------------------
// A byte that yields at most one command is taken every cycle while the command
// side keeps up. A data byte that crosses into a new page while the old one is
// dirty, or an end-of-file checksum byte with a dirty page, yields three
// commands. The command queue has a single output that drains one command per
// cycle while out_stall is low, so the next byte then waits and is taken in
// the cycle that the third command leaves. Bytes after the start-application
// command are taken and dropped. PAGE_BYTES must be a power of two.

module hex_record_page_programmer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rec_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  opcode,
	output logic [19:0] cmd_address,
	output logic [15:0] fill_word,
	output logic        last
);

	hrpp_pkg::cmd_bundle_t bundle;
	hrpp_pkg::cmd_t        head;
	logic                  can_load;
	logic                  take;

	assign in_stall = !can_load;
	assign take     = in_valid && can_load;

	hrpp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.rec_byte (rec_byte),
		.bundle   (bundle)
	);

	hrpp_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.bundle    (bundle),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head),
		.last      (last)
	);

	assign opcode      = head.opcode;
	assign cmd_address = head.address;
	assign fill_word   = head.word;

endmodule

// File: hdl/hrpp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrpp_parser
// Record framing state and command generation for one stream byte.
// ----------------------------------------------------------------------------
`include "hex_record_page_programmer_unit_defines.svh"

module hrpp_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           rec_byte,
	output hrpp_pkg::cmd_bundle_t bundle
);

	hrpp_pkg::field_pos_t pos_q, pos_n;
	logic [7:0]  len_q, len_n;
	logic [7:0]  left_q, left_n;
	logic [16:0] addr_q, addr_n;
	logic [7:0]  type_q, type_n;
	logic [19:0] base_q, base_n;
	logic [19:0] page_q, page_n;
	logic        dirty_q, dirty_n;
	logic [7:0]  hold_q, hold_n;
	logic        phase_q, phase_n;
	logic        finished_q, finished_n;

	logic [7:0]  idx;
	logic [7:0]  eff;
	logic [8:0]  idx_inc;
	logic [19:0] full_addr;
	logic [19:0] word_page;
	logic        emit;
	logic        eof;
	logic [15:0] word;
	logic        flush;
	hrpp_pkg::cmd_t tail;

	assign idx       = len_q - left_q;
	assign eff       = (len_q < hrpp_pkg::MAX_DATA_LEN) ? len_q : hrpp_pkg::MAX_DATA_LEN;
	assign idx_inc   = {1'b0, idx} + 9'd1;
	assign full_addr = {3'b000, addr_q} + base_q;
	assign word_page = full_addr & ~hrpp_pkg::PAGE_MASK;

	always_comb begin
		pos_n      = pos_q;
		len_n      = len_q;
		left_n     = left_q;
		addr_n     = addr_q;
		type_n     = type_q;
		base_n     = base_q;
		page_n     = page_q;
		dirty_n    = dirty_q;
		hold_n     = hold_q;
		phase_n    = phase_q;
		finished_n = finished_q;
		emit       = 1'b0;
		eof        = 1'b0;
		word       = '0;
		if (!finished_q) begin
			case (pos_q)
				hrpp_pkg::POS_SYNC: begin
					pos_n = hrpp_pkg::POS_LEN;
				end
				hrpp_pkg::POS_LEN: begin
					len_n   = rec_byte;
					left_n  = rec_byte;
					phase_n = 1'b0;
					pos_n   = hrpp_pkg::POS_ALO;
				end
				hrpp_pkg::POS_ALO: begin
					addr_n = {9'd0, rec_byte};
					pos_n  = hrpp_pkg::POS_AHI;
				end
				hrpp_pkg::POS_AHI: begin
					addr_n = {1'b0, rec_byte, addr_q[7:0]};
					pos_n  = hrpp_pkg::POS_TYPE;
				end
				hrpp_pkg::POS_TYPE: begin
					type_n = rec_byte;
					pos_n  = (left_q == 8'd0) ? hrpp_pkg::POS_CKSUM : hrpp_pkg::POS_DATA;
				end
				hrpp_pkg::POS_DATA: begin
					if (type_q == hrpp_pkg::REC_DATA && idx < eff) begin
						if (!phase_q) begin
							hold_n = rec_byte;
							// trailing odd byte goes out with a zero high byte
							if (idx_inc == {1'b0, eff}) begin
								emit    = 1'b1;
								word    = {8'd0, rec_byte};
								phase_n = 1'b0;
							end else begin
								phase_n = 1'b1;
							end
						end else begin
							emit    = 1'b1;
							word    = {rec_byte, hold_q};
							phase_n = 1'b0;
						end
					end else if (type_q == hrpp_pkg::REC_EXT_SEG && idx == 8'd0) begin
						base_n = {rec_byte, 12'd0};
					end
					left_n = left_q - 8'd1;
					if (left_q == 8'd1) begin
						pos_n = hrpp_pkg::POS_CKSUM;
					end
				end
				default: begin
					// checksum byte: consume, act on end of file
					if (type_q == hrpp_pkg::REC_EOF) begin
						eof        = 1'b1;
						finished_n = 1'b1;
					end
					pos_n = hrpp_pkg::POS_SYNC;
				end
			endcase
		end
		if (emit) begin
			page_n  = word_page;
			addr_n  = addr_q + 17'd2;
			dirty_n = 1'b1;
		end
	end

	assign flush = dirty_q && (eof || (emit && word_page != page_q));

	always_comb begin
		tail.opcode  = emit ? hrpp_pkg::OP_FILL : hrpp_pkg::OP_START;
		tail.address = emit ? {4'd0, addr_q[15:0]} : 20'd0;
		tail.word    = emit ? word : 16'd0;
		bundle       = '0;
		if (flush) begin
			bundle.cmds[0].opcode  = hrpp_pkg::OP_ERASE;
			bundle.cmds[0].address = page_q;
			bundle.cmds[1].opcode  = hrpp_pkg::OP_WRITE;
			bundle.cmds[1].address = page_q;
			bundle.cmds[2]         = tail;
			bundle.count           = hrpp_pkg::CNT_W'(3);
		end else if (emit || eof) begin
			bundle.cmds[0] = tail;
			bundle.count   = hrpp_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= hrpp_pkg::POS_SYNC;
			len_q      <= '0;
			left_q     <= '0;
			addr_q     <= '0;
			type_q     <= '0;
			base_q     <= '0;
			page_q     <= '0;
			dirty_q    <= 1'b0;
			hold_q     <= '0;
			phase_q    <= 1'b0;
			finished_q <= 1'b0;
		end else if (take) begin
			pos_q      <= pos_n;
			len_q      <= len_n;
			left_q     <= left_n;
			addr_q     <= addr_n;
			type_q     <= type_n;
			base_q     <= base_n;
			page_q     <= page_n;
			dirty_q    <= dirty_n;
			hold_q     <= hold_n;
			phase_q    <= phase_n;
			finished_q <= finished_n;
		end
	end

	`HRPP_ASSERT_NEXT(a_finished_sticky, finished_q, finished_q)
	`HRPP_ASSERT_NEXT(a_dirty_sticky, dirty_q, dirty_q)
	`HRPP_ASSERT_IMPL(a_silent_after_start, finished_q, bundle.count == '0)

endmodule

// File: hdl/hrpp_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrpp_cmd_queue
// Result register holding the commands of one byte, drained one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`include "hex_record_page_programmer_unit_defines.svh"

module hrpp_cmd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  hrpp_pkg::cmd_bundle_t bundle,
	output logic                  can_load,
	output logic                  out_valid,
	input  logic                  out_stall,
	output hrpp_pkg::cmd_t        head,
	output logic                  last
);

	hrpp_pkg::cmd_t [hrpp_pkg::MAX_CMDS-1:0] entry_q;
	logic [hrpp_pkg::CNT_W-1:0]              cnt_q;
	logic                                    pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = entry_q[0];
	assign last      = (cnt_q == hrpp_pkg::CNT_W'(1));
	// take a new byte when empty or once the final pending command leaves
	assign can_load  = (cnt_q == '0) || (last && !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= bundle.count;
		end else if (pop) begin
			cnt_q <= cnt_q - hrpp_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= bundle.cmds;
		end else if (pop) begin
			for (int i = 0; i < hrpp_pkg::MAX_CMDS - 1; i++) begin
				entry_q[i] <= entry_q[i+1];
			end
			entry_q[hrpp_pkg::MAX_CMDS-1] <= '0;
		end
	end

	`HRPP_ASSERT_IMPL(a_load_when_drained, load, cnt_q == '0 || (last && pop))
	`HRPP_ASSERT_NEXT(a_pop_advances, pop && !load, cnt_q == $past(cnt_q) - hrpp_pkg::CNT_W'(1))
	`HRPP_ASSERT_NEXT(a_load_shows, load && bundle.count != '0, out_valid)

endmodule
